// ----- rtl/core/efwd_pkg.sv -----
// ----------------------------------------------------------------------------
// efwd_pkg
// Shared types and constants for the earliest free worker dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package efwd_pkg;

  localparam int WORKERS  = 16;
  localparam int TIME_W   = 48;
  localparam int DUR_W    = 32;
  localparam int CNT_W    = 5;
  localparam int WORKER_W = 4;
  localparam int IDX_W    = (WORKERS > 1) ? $clog2(WORKERS) : 1;

  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(16);

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              have;
    logic [TIME_W-1:0] best_time;
    logic [IDX_W-1:0]  best_idx;
  } srch_t;

  // free time write-back to the chosen cell
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] free_time;
  } upd_t;

  // worker zero always takes part, others only below the programmed count
  function automatic logic worker_active(input logic [CNT_W-1:0] cnt,
                                         input int unsigned idx);
    return (idx == 0) || (32'(cnt) > idx);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/efwd_cell.sv -----
// ----------------------------------------------------------------------------
// efwd_cell
// One worker: holds its free time and folds it into the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none

module efwd_cell import efwd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic             active,
  input  wire srch_t            srch_in,
  input  wire upd_t             upd,
  output srch_t                 srch_out
);

  logic [TIME_W-1:0] free_time_r;
  srch_t             srch_r;
  srch_t             srch_nxt;
  logic              take;

  // strict less-than keeps ties on the lower index
  always_comb begin
    take     = active && (!srch_in.have || (free_time_r < srch_in.best_time));
    srch_nxt = srch_in;
    if (take) begin
      srch_nxt.have      = 1'b1;
      srch_nxt.best_time = free_time_r;
      srch_nxt.best_idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_time_r  <= '0;
      srch_r.valid <= 1'b0;
    end else begin
      srch_r.valid <= srch_nxt.valid;
      if (upd.valid && (upd.idx == cell_idx)) begin
        free_time_r <= upd.free_time;
      end
    end
    srch_r.have      <= srch_nxt.have;
    srch_r.best_time <= srch_nxt.best_time;
    srch_r.best_idx  <= srch_nxt.best_idx;
  end

  assign srch_out = srch_r;

endmodule

`default_nettype wire

// ----- rtl/core/earliest_free_worker_dispatch.sv -----
// ----------------------------------------------------------------------------
// earliest_free_worker_dispatch
// Assigns each job to the worker that is free earliest and reports its start.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | request   | in_valid / in_stall | in_duration[31:0]
//  out     | result    | out_valid/out_stall | out_worker[3:0], out_start_time[47:0]
//  cfg     | write     | cfg_we              | cfg_wdata[4:0] (worker count)
//
//  the search token walks the cell row one cell per cycle, through one register
//  per cell; as it leaves the last cell the chosen free time is written back and
//  the result is held in a pending register, then moved into the output register
//  a new request is taken while the previous result waits in the output register
//  reset is synchronous; all free times clear to zero, worker count to 16
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_free_worker_dispatch import efwd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [DUR_W-1:0]    in_duration,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORKER_W-1:0]      out_worker,
  output logic [TIME_W-1:0]        out_start_time
);

  logic [CNT_W-1:0]    worker_count_r;
  logic                busy_r;
  logic                pend_valid_r;
  logic [IDX_W-1:0]    pend_idx_r;
  logic [TIME_W-1:0]   pend_start_r;
  logic [DUR_W-1:0]    dur_r;
  logic                out_valid_r;
  logic [WORKER_W-1:0] out_worker_r;
  logic [TIME_W-1:0]   out_start_r;

  srch_t               chain [WORKERS+1];
  upd_t                upd;
  logic                in_acc;
  logic                done;
  logic                out_load;
  logic [TIME_W:0]     sum;

  assign in_stall = busy_r || pend_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign done     = chain[WORKERS].valid;
  assign out_load = pend_valid_r && (!out_valid_r || !out_stall);

  // token enters the row with no candidate yet
  assign chain[0].valid     = in_acc;
  assign chain[0].have      = 1'b0;
  assign chain[0].best_time = TIME_MAX;
  assign chain[0].best_idx  = '0;

  for (genvar i = 0; i < WORKERS; i++) begin : g_cell
    efwd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .active   (worker_active(worker_count_r, i)),
      .srch_in  (chain[i]),
      .upd      (upd),
      .srch_out (chain[i+1])
    );
  end

  // saturating free time update
  always_comb begin
    sum           = {1'b0, chain[WORKERS].best_time} + (TIME_W+1)'(dur_r);
    upd.valid     = done;
    upd.idx       = chain[WORKERS].best_idx;
    upd.free_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= CNT_RESET;
      busy_r         <= 1'b0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        worker_count_r <= cfg_wdata;
      end
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        pend_valid_r <= 1'b1;
      end else if (out_load) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      dur_r <= in_duration;
    end
    if (done) begin
      pend_idx_r   <= chain[WORKERS].best_idx;
      pend_start_r <= chain[WORKERS].best_time;
    end
    if (out_load) begin
      out_worker_r <= WORKER_W'(pend_idx_r);
      out_start_r  <= pend_start_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_worker     = out_worker_r;
  assign out_start_time = out_start_r;

endmodule

`default_nettype wire

// ----- rtl/core/efwd_chk.sv -----
// ----------------------------------------------------------------------------
// efwd_chk
// Port-level checks on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efwd_chk import efwd_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [WORKER_W-1:0] out_worker,
  input wire logic [TIME_W-1:0]   out_start_time
);

  logic [1:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_worker) && $stable(out_start_time)))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result without an outstanding request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (pending_r < 2'd2))
    else $error("too many requests outstanding");

  a_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request taken while search still running");

endmodule

bind earliest_free_worker_dispatch efwd_chk u_efwd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_worker     (out_worker),
  .out_start_time (out_start_time)
);

`default_nettype wire
